>>> rtl/core/fjrr_pkg.sv
// Package for the feeder jam reverse and wheel ramp block: types, codes and reset values.
`default_nettype none

package fjrr_pkg;

    // Register map codes; register i lives at byte address 4*i.
    typedef enum logic [2:0] {
        REG_JAM_CURRENT_LIMIT = 3'd0,
        REG_JAM_SPEED_LIMIT   = 3'd1,
        REG_JAM_COUNT_LIMIT   = 3'd2,
        REG_REVERSE_TICKS     = 3'd3,
        REG_FEED_SPEED        = 3'd4,
        REG_WHEEL_MAX_SPEED   = 3'd5,
        REG_RAMP_STEP         = 3'd6
    } fjrr_reg_t;

    localparam int unsigned ADDR_W = 5;

    // Register reset values.
    localparam logic        [14:0] JAM_CURRENT_LIMIT_RST = 15'd4000;
    localparam logic signed [15:0] JAM_SPEED_LIMIT_RST   = 16'sd1;
    localparam logic        [10:0] JAM_COUNT_LIMIT_RST   = 11'd500;
    localparam logic        [11:0] REVERSE_TICKS_RST     = 12'd1000;
    localparam logic        [14:0] FEED_SPEED_RST        = 15'd0;
    localparam logic        [22:0] WHEEL_MAX_SPEED_RST   = 23'd0;
    localparam logic        [22:0] RAMP_STEP_RST         = 23'd0;

    // Jam counter saturates here.
    localparam logic [11:0] JAM_COUNT_MAX = 12'd4095;

    typedef struct packed {
        logic        [14:0] jam_current_limit;
        logic signed [15:0] jam_speed_limit;
        logic        [10:0] jam_count_limit;
        logic        [11:0] reverse_ticks;
        logic        [14:0] feed_speed;
        logic        [22:0] wheel_max_speed;
        logic        [22:0] ramp_step;
    } fjrr_cfg_t;

    typedef struct packed {
        logic               no_force;
        logic               wheels_on;
        logic               feed_on;
        logic signed [15:0] feeder_a_drive;
        logic signed [15:0] feeder_b_drive;
        logic signed [15:0] feeder_a_rpm;
        logic signed [15:0] feeder_b_rpm;
    } fjrr_in_t;

    typedef struct packed {
        logic signed [23:0] wheel_a_set;
        logic signed [23:0] wheel_b_set;
        logic signed [23:0] wheel_c_set;
        logic signed [23:0] wheel_d_set;
        logic signed [15:0] feeder_set;
        logic               reversing;
    } fjrr_out_t;

endpackage

`default_nettype wire

>>> rtl/core/feeder_jam_reverse_and_ramp.sv
// Top level: register port, per-tick logic and a two-entry output buffer.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data  (fjrr_in_t)
//   out       output     out_valid/out_stall out_data (fjrr_out_t)
//   cfg       APB        psel/penable/pready paddr, pwdata, prdata
//
// One tick per cycle while in_stall is low: the result is computed in the
// accepting cycle and registered in the output register, or in the skid register.
// A skid register behind the output register lets one more beat in while the
// output is stalled; in_stall rises only when that skid entry is full.
// Reset clears the ramp and both counters and loads the register defaults.
`default_nettype none

module feeder_jam_reverse_and_ramp
    import fjrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fjrr_in_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fjrr_out_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    fjrr_cfg_t cfg_reg;
    fjrr_out_t tick_result;
    fjrr_out_t out_reg;
    fjrr_out_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      in_acc;
    logic      out_take;
    logic      cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jam_current_limit <= JAM_CURRENT_LIMIT_RST;
            cfg_reg.jam_speed_limit   <= JAM_SPEED_LIMIT_RST;
            cfg_reg.jam_count_limit   <= JAM_COUNT_LIMIT_RST;
            cfg_reg.reverse_ticks     <= REVERSE_TICKS_RST;
            cfg_reg.feed_speed        <= FEED_SPEED_RST;
            cfg_reg.wheel_max_speed   <= WHEEL_MAX_SPEED_RST;
            cfg_reg.ramp_step         <= RAMP_STEP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_JAM_CURRENT_LIMIT: cfg_reg.jam_current_limit <= pwdata[14:0];
                REG_JAM_SPEED_LIMIT:   cfg_reg.jam_speed_limit   <= $signed(pwdata[15:0]);
                REG_JAM_COUNT_LIMIT:   cfg_reg.jam_count_limit   <= pwdata[10:0];
                REG_REVERSE_TICKS:     cfg_reg.reverse_ticks     <= pwdata[11:0];
                REG_FEED_SPEED:        cfg_reg.feed_speed        <= pwdata[14:0];
                REG_WHEEL_MAX_SPEED:   cfg_reg.wheel_max_speed   <= pwdata[22:0];
                REG_RAMP_STEP:         cfg_reg.ramp_step         <= pwdata[22:0];
                default:               ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (cfg_idx)
            REG_JAM_CURRENT_LIMIT: prdata = {17'd0, cfg_reg.jam_current_limit};
            REG_JAM_SPEED_LIMIT:   prdata = {{16{cfg_reg.jam_speed_limit[15]}},
                                             cfg_reg.jam_speed_limit};
            REG_JAM_COUNT_LIMIT:   prdata = {21'd0, cfg_reg.jam_count_limit};
            REG_REVERSE_TICKS:     prdata = {20'd0, cfg_reg.reverse_ticks};
            REG_FEED_SPEED:        prdata = {17'd0, cfg_reg.feed_speed};
            REG_WHEEL_MAX_SPEED:   prdata = {9'd0, cfg_reg.wheel_max_speed};
            REG_RAMP_STEP:         prdata = {9'd0, cfg_reg.ramp_step};
            default:               prdata = 32'd0;
        endcase
    end

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    fjrr_tick u_tick (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_acc),
        .cfg    (cfg_reg),
        .item   (in_data),
        .result (tick_result)
    );

    // Output buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_acc && out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            if (out_take)
            begin
                out_valid_reg <= skid_valid_reg || in_acc;
            end
            else
            begin
                out_valid_reg <= out_valid_reg || in_acc;
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= tick_result;
            end
            else
            begin
                skid_reg <= tick_result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/fjrr_tick.sv
// Per-tick logic: wheel ramp, jam counter and reverse counter with the result they give.
`default_nettype none

module fjrr_tick
    import fjrr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire fjrr_cfg_t cfg,
    input  wire fjrr_in_t  item,
    output fjrr_out_t      result
);

    logic [22:0] ramp_reg, ramp_next;
    logic [11:0] jam_count_reg, jam_count_next;
    logic [11:0] reverse_count_reg, reverse_count_next;

    logic [22:0] target;
    logic [23:0] up_sum;
    logic [23:0] dn_diff;
    logic [22:0] ramp_up;
    logic [22:0] ramp_dn;
    logic        jam;
    logic        rev;
    logic [11:0] jam_inc;
    logic [15:0] feed_mag;
    logic [23:0] ramp_ext;
    logic signed [16:0] cur_lim;

    // Step-limited approach of the ramp toward its target.
    always_comb
    begin
        target  = item.wheels_on ? cfg.wheel_max_speed : 23'd0;
        up_sum  = {1'b0, ramp_reg} + {1'b0, cfg.ramp_step};
        dn_diff = {1'b0, ramp_reg} - {1'b0, cfg.ramp_step};
        ramp_up = (up_sum > {1'b0, target}) ? target : up_sum[22:0];
        ramp_dn = (dn_diff[23] || (dn_diff[22:0] < target)) ? target : dn_diff[22:0];
        if (item.no_force)
        begin
            ramp_next = 23'd0;
        end
        else if (ramp_reg < target)
        begin
            ramp_next = ramp_up;
        end
        else if (ramp_reg > target)
        begin
            ramp_next = ramp_dn;
        end
        else
        begin
            ramp_next = ramp_reg;
        end
    end

    // A jam tick needs both feeders straining and both stalled.
    always_comb
    begin
        cur_lim = $signed({2'b00, cfg.jam_current_limit});
        jam = ($signed({item.feeder_a_drive[15], item.feeder_a_drive}) > cur_lim)
           && ($signed({item.feeder_b_drive[15], item.feeder_b_drive}) > cur_lim)
           && (item.feeder_a_rpm < cfg.jam_speed_limit)
           && (item.feeder_b_rpm < cfg.jam_speed_limit);
    end

    // Jam and reverse counters.
    always_comb
    begin
        rev                = (!item.no_force) && (reverse_count_reg != 12'd0);
        jam_inc            = (jam && (jam_count_reg != JAM_COUNT_MAX))
                           ? jam_count_reg + 12'd1 : jam_count_reg;
        jam_count_next     = jam_count_reg;
        reverse_count_next = reverse_count_reg;
        if (!item.no_force)
        begin
            if (rev)
            begin
                reverse_count_next = reverse_count_reg - 12'd1;
            end
            else if (jam_inc > {1'b0, cfg.jam_count_limit})
            begin
                reverse_count_next = cfg.reverse_ticks;
                jam_count_next     = 12'd0;
            end
            else
            begin
                jam_count_next = jam_inc;
            end
        end
    end

    // Result fields from the updated ramp and the branch taken.
    always_comb
    begin
        feed_mag           = {1'b0, cfg.feed_speed};
        ramp_ext           = {1'b0, ramp_next};
        result.wheel_a_set = $signed(-ramp_ext);
        result.wheel_b_set = $signed(ramp_ext);
        result.wheel_c_set = $signed(ramp_ext);
        result.wheel_d_set = $signed(-ramp_ext);
        if (item.no_force || !item.feed_on)
        begin
            result.feeder_set = 16'sd0;
        end
        else if (rev)
        begin
            result.feeder_set = $signed(-feed_mag);
        end
        else
        begin
            result.feeder_set = $signed(feed_mag);
        end
        result.reversing = rev;
    end

    // State advances once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg          <= 23'd0;
            jam_count_reg     <= 12'd0;
            reverse_count_reg <= 12'd0;
        end
        else if (accept)
        begin
            ramp_reg          <= ramp_next;
            jam_count_reg     <= jam_count_next;
            reverse_count_reg <= reverse_count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fjrr_checker.sv
// Port-level checks for the feeder jam reverse and wheel ramp block, with its bind.
`default_nettype none

module fjrr_checker
    import fjrr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire fjrr_out_t out_data
);

    // A stalled output beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // The input side only stalls when both buffer entries hold results.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // Wheel pairs mirror the ramp, which never goes negative.
    a_wheel_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.wheel_b_set == out_data.wheel_c_set)
                   && (out_data.wheel_a_set == out_data.wheel_d_set)
                   && (out_data.wheel_a_set == 24'(-out_data.wheel_b_set))
                   && !out_data.wheel_b_set[23])
        else $error("wheel setpoints inconsistent");

    // Feeder direction follows the reversing flag.
    a_feed_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.reversing ? !(out_data.feeder_set > 16'sd0)
                                          : !out_data.feeder_set[15]))
        else $error("feeder setpoint sign does not match reversing flag");

endmodule

bind feeder_jam_reverse_and_ramp fjrr_checker u_fjrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> sim/feeder_jam_reverse_and_ramp_tb.sv
// Self-checking testbench for the feeder jam reverse and friction wheel ramp block.
`timescale 1ns / 100ps

module feeder_jam_reverse_and_ramp_tb
    import fjrr_pkg::*;
();

    // Register index with no register behind it; writes to it must be ignored.
    localparam int REG_UNUSED = 7;
    // Length of the long output hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 300;

    typedef enum {SETUP_LOWEST, SETUP_HIGHEST, SETUP_RANDOM} setup_kind_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    fjrr_in_t          in_data;
    logic              out_valid;
    logic              out_stall = 1'b0;
    fjrr_out_t         out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Register shadow and the tick state that the block should hold.
    fjrr_cfg_t          regs;
    logic signed [23:0] wheel_ramp_q;
    logic [11:0]        jam_ticks;
    logic [11:0]        reverse_left;

    // Setpoints still to come out of the block, oldest first.
    fjrr_out_t pending_setpoints[$];
    fjrr_out_t oldest;
    int        fail_count = 0;

    // Idle rates in percent, and the hold-off request counter.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    feeder_jam_reverse_and_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Both feeders straining and both below the stall speed.
    function automatic bit is_jam(input fjrr_in_t t);
        int lim;
        int spd;
        lim = int'(regs.jam_current_limit);
        spd = int'($signed(regs.jam_speed_limit));
        return int'($signed(t.feeder_a_drive)) > lim && int'($signed(t.feeder_b_drive)) > lim
            && int'($signed(t.feeder_a_rpm)) < spd && int'($signed(t.feeder_b_rpm)) < spd;
    endfunction

    // Advance the tick state by one beat and return the setpoints it produces.
    function automatic fjrr_out_t advance_feeder_tick(input fjrr_in_t t);
        fjrr_out_t          o;
        int                 target;
        int                 r;
        logic signed [15:0] feed;
        logic               rev;
        feed = '0;
        rev  = 1'b0;
        if (t.no_force)
        begin
            wheel_ramp_q = '0;
        end
        else
        begin
            // Step-limited approach of the wheel ramp to its target.
            target = t.wheels_on ? int'(regs.wheel_max_speed) : 0;
            r = int'(wheel_ramp_q);
            if (r < target)
            begin
                r = r + int'(regs.ramp_step);
                if (r > target)
                    r = target;
            end
            else if (r > target)
            begin
                r = r - int'(regs.ramp_step);
                if (r < target)
                    r = target;
            end
            wheel_ramp_q = 24'(r);

            // Reverse period runs first; jam detection only on forward ticks.
            if (reverse_left != 0)
            begin
                reverse_left = reverse_left - 1'b1;
                rev = 1'b1;
                if (t.feed_on)
                    feed = -$signed({1'b0, regs.feed_speed});
            end
            else
            begin
                if (is_jam(t) && jam_ticks < JAM_COUNT_MAX)
                    jam_ticks = jam_ticks + 1'b1;
                if (jam_ticks > 12'(regs.jam_count_limit))
                begin
                    reverse_left = regs.reverse_ticks;
                    jam_ticks    = '0;
                end
                if (t.feed_on)
                    feed = $signed({1'b0, regs.feed_speed});
            end
        end
        o.wheel_a_set = -wheel_ramp_q;
        o.wheel_b_set = wheel_ramp_q;
        o.wheel_c_set = wheel_ramp_q;
        o.wheel_d_set = -wheel_ramp_q;
        o.feeder_set  = feed;
        o.reversing   = rev;
        return o;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic fjrr_in_t make_tick(input bit nf, input bit wo, input bit fo,
                                           input int da, input int db,
                                           input int ra, input int rb);
        fjrr_in_t t;
        t.no_force       = nf;
        t.wheels_on      = wo;
        t.feed_on        = fo;
        t.feeder_a_drive = clamp16(da);
        t.feeder_b_drive = clamp16(db);
        t.feeder_a_rpm   = clamp16(ra);
        t.feeder_b_rpm   = clamp16(rb);
        return t;
    endfunction

    // Mostly jam-shaped ticks, some right at the thresholds, the rest raw noise.
    function automatic fjrr_in_t random_tick();
        fjrr_in_t    t;
        logic [95:0] raw;
        int          lim;
        int          spd;
        int          pick;
        raw  = {$urandom(), $urandom(), $urandom()};
        t    = raw[$bits(fjrr_in_t)-1:0];
        lim  = int'(regs.jam_current_limit);
        spd  = int'($signed(regs.jam_speed_limit));
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            if (lim < 32767)
            begin
                t.feeder_a_drive = 16'(lim + 1 + int'($urandom_range(32766 - lim)));
                t.feeder_b_drive = 16'(lim + 1 + int'($urandom_range(32766 - lim)));
            end
            if (spd > -32768)
            begin
                t.feeder_a_rpm = 16'(-32768 + int'($urandom_range(spd + 32767)));
                t.feeder_b_rpm = 16'(-32768 + int'($urandom_range(spd + 32767)));
            end
        end
        else if (pick < 80)
        begin
            t.feeder_a_drive = clamp16(lim + int'($urandom_range(2)) - 1);
            t.feeder_b_drive = clamp16(lim + int'($urandom_range(2)) - 1);
            t.feeder_a_rpm   = clamp16(spd + int'($urandom_range(2)) - 1);
            t.feeder_b_rpm   = clamp16(spd + int'($urandom_range(2)) - 1);
        end
        if (pick < 80)
        begin
            t.no_force  = ($urandom_range(24) == 0);
            t.wheels_on = ($urandom_range(9) < 7);
            t.feed_on   = ($urandom_range(9) < 7);
        end
        return t;
    endfunction

    // Receiver side: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Output side: each beat is checked against the oldest prediction.
    // Handshake signals are stable at the falling edge, so the beat is known there.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_setpoints.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected output beat: %p", out_data);
            end
            else
            begin
                oldest = pending_setpoints.pop_front();
                check_field("wheel_a_set", oldest.wheel_a_set, out_data.wheel_a_set);
                check_field("wheel_b_set", oldest.wheel_b_set, out_data.wheel_b_set);
                check_field("wheel_c_set", oldest.wheel_c_set, out_data.wheel_c_set);
                check_field("wheel_d_set", oldest.wheel_d_set, out_data.wheel_d_set);
                check_field("feeder_set", 24'(oldest.feeder_set), 24'(out_data.feeder_set));
                check_field("reversing", 24'(oldest.reversing), 24'(out_data.reversing));
            end
        end
    end

    // Offer one input beat, with a random gap before it, and predict its setpoints.
    task automatic send_tick(input fjrr_in_t t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        pending_setpoints.push_back(advance_feeder_tick(t));
    endtask

    // Stop offering beats and wait until every predicted beat has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
    endtask

    // Register write: setup cycle, access cycle, then an idle cycle.
    task automatic write_register(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_JAM_CURRENT_LIMIT: regs.jam_current_limit = value[14:0];
            REG_JAM_SPEED_LIMIT:   regs.jam_speed_limit   = value[15:0];
            REG_JAM_COUNT_LIMIT:   regs.jam_count_limit   = value[10:0];
            REG_REVERSE_TICKS:     regs.reverse_ticks     = value[11:0];
            REG_FEED_SPEED:        regs.feed_speed        = value[14:0];
            REG_WHEEL_MAX_SPEED:   regs.wheel_max_speed   = value[22:0];
            REG_RAMP_STEP:         regs.ramp_step         = value[22:0];
            default: ;
        endcase
    endtask

    // Write every register: all lowest, all highest, or a random mix.
    task automatic load_setup(input setup_kind_t kind);
        logic [31:0] vals [7];
        case (kind)
            SETUP_LOWEST:
            begin
                vals[REG_JAM_CURRENT_LIMIT] = 32'd0;
                vals[REG_JAM_SPEED_LIMIT]   = 32'h0000_8000;
                vals[REG_JAM_COUNT_LIMIT]   = 32'd0;
                vals[REG_REVERSE_TICKS]     = 32'd0;
                vals[REG_FEED_SPEED]        = 32'd0;
                vals[REG_WHEEL_MAX_SPEED]   = 32'd0;
                vals[REG_RAMP_STEP]         = 32'd0;
            end
            SETUP_HIGHEST:
            begin
                vals[REG_JAM_CURRENT_LIMIT] = 32'd32767;
                vals[REG_JAM_SPEED_LIMIT]   = 32'd32767;
                vals[REG_JAM_COUNT_LIMIT]   = 32'd2047;
                vals[REG_REVERSE_TICKS]     = 32'd4095;
                vals[REG_FEED_SPEED]        = 32'd32767;
                vals[REG_WHEEL_MAX_SPEED]   = 32'd8388607;
                vals[REG_RAMP_STEP]         = 32'd8388607;
            end
            default:
            begin
                vals[REG_JAM_CURRENT_LIMIT] = ($urandom_range(3) == 0) ?
                                              $urandom_range(32767) : $urandom_range(8000);
                vals[REG_JAM_SPEED_LIMIT]   = $urandom_range(65535);
                vals[REG_JAM_COUNT_LIMIT]   = ($urandom_range(7) == 0) ?
                                              $urandom_range(2047) : $urandom_range(12);
                vals[REG_REVERSE_TICKS]     = ($urandom_range(7) == 0) ?
                                              $urandom_range(4095) : $urandom_range(30);
                vals[REG_FEED_SPEED]        = $urandom_range(32767);
                vals[REG_WHEEL_MAX_SPEED]   = $urandom_range(8388607);
                vals[REG_RAMP_STEP]         = ($urandom_range(3) == 0) ?
                                              $urandom_range(8388607) : $urandom_range(524287);
            end
        endcase
        for (int i = 0; i <= REG_RAMP_STEP; i++)
            write_register(i, vals[i]);
    endtask

    // Reset defaults, with every input field at its extremes and one disabled tick.
    task automatic test_reset_defaults();
        send_tick(make_tick(0, 1, 1, 32767, 32767, -32768, -32768));
        send_tick(make_tick(0, 0, 0, -32768, -32768, 32767, 32767));
        send_tick(make_tick(1, 1, 1, 0, 0, 0, 0));
    endtask

    // Ramp up and down, disable clearing, full-size step and a zero step.
    task automatic test_wheel_ramp();
        wait_idle();
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        write_register(REG_WHEEL_MAX_SPEED, 32'd1000);
        write_register(REG_RAMP_STEP, 32'd300);
        repeat (4) send_tick(make_tick(0, 1, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(1, 1, 0, 0, 0, 0, 0));
        wait_idle();
        write_register(REG_WHEEL_MAX_SPEED, 32'd8388607);
        write_register(REG_RAMP_STEP, 32'd8388607);
        send_tick(make_tick(0, 1, 0, 0, 0, 0, 0));
        wait_idle();
        // With a zero step the ramp holds until a disabled tick clears it.
        write_register(REG_RAMP_STEP, 32'd0);
        send_tick(make_tick(0, 1, 1, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 0, 0, 0, 0));
        send_tick(make_tick(1, 0, 1, 0, 0, 0, 0));
    endtask

    // Jam ticks at the thresholds start a short reverse period.
    task automatic test_jam_reverse();
        wait_idle();
        write_register(REG_JAM_CURRENT_LIMIT, 32'd100);
        write_register(REG_JAM_SPEED_LIMIT, 32'd10);
        write_register(REG_JAM_COUNT_LIMIT, 32'd1);
        write_register(REG_REVERSE_TICKS, 32'd2);
        write_register(REG_FEED_SPEED, 32'd32767);
        send_tick(make_tick(0, 0, 1, 100, 101, 9, 9));
        send_tick(make_tick(0, 0, 1, 101, 101, 9, 9));
        send_tick(make_tick(0, 0, 1, 101, 101, 9, 9));
        // A disabled tick in the middle must leave both counters alone.
        send_tick(make_tick(1, 0, 1, 101, 101, 9, 9));
        send_tick(make_tick(0, 0, 0, 101, 101, 9, 9));
        send_tick(make_tick(0, 0, 1, 101, 101, 10, 9));
    endtask

    // Lowering the count limit below the held count reverses on a clean tick.
    // The jam counter cannot reach its saturation value with an 11-bit limit.
    task automatic test_limit_lowered();
        wait_idle();
        write_register(REG_JAM_COUNT_LIMIT, 32'd2047);
        repeat (3) send_tick(make_tick(0, 1, 1, 32767, 32767, -32768, -32768));
        wait_idle();
        write_register(REG_JAM_COUNT_LIMIT, 32'd0);
        write_register(REG_REVERSE_TICKS, 32'd1);
        send_tick(make_tick(0, 1, 1, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 1, 0, 0, 0, 0));
    endtask

    // Random beats in four segments, each under a fresh register setting.
    task automatic test_random_traffic(input int tx_idle, input int rx_idle,
                                       input setup_kind_t first);
        for (int seg = 0; seg < 4; seg++)
        begin
            wait_idle();
            if (seg == 0)
            begin
                send_idle_pct  = tx_idle;
                recv_idle_pct <= rx_idle;
            end
            load_setup((seg == 0) ? first : SETUP_RANDOM);
            repeat (100) send_tick(random_tick());
        end
    endtask

    // Receiver holds off for a long stretch while beats keep coming.
    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        hold_seq      <= hold_seq + 1;
        load_setup(SETUP_RANDOM);
        repeat (40) send_tick(random_tick());
    endtask

    // Main sequence.
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        regs.jam_current_limit = JAM_CURRENT_LIMIT_RST;
        regs.jam_speed_limit   = JAM_SPEED_LIMIT_RST;
        regs.jam_count_limit   = JAM_COUNT_LIMIT_RST;
        regs.reverse_ticks     = REVERSE_TICKS_RST;
        regs.feed_speed        = FEED_SPEED_RST;
        regs.wheel_max_speed   = WHEEL_MAX_SPEED_RST;
        regs.ramp_step         = RAMP_STEP_RST;
        wheel_ramp_q = '0;
        jam_ticks    = '0;
        reverse_left = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_wheel_ramp();
        test_jam_reverse();
        test_limit_lowered();
        test_random_traffic(10, 88, SETUP_LOWEST);
        test_random_traffic(88, 10, SETUP_HIGHEST);
        test_random_traffic(0, 0, SETUP_RANDOM);
        test_output_backpressure();

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_setpoints.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
